@@ rtl/gtbp_pkg.sv @@
`default_nettype none

package gtbp_pkg;

    localparam int LANES     = 8;
    localparam int PIX_W     = 8;
    localparam int WORD_W    = LANES * PIX_W;
    localparam int ACC_W     = WORD_W - LANES;
    localparam int GRP_W     = 3;
    localparam int DIM_W     = 14;
    localparam int WIR_W     = 11;
    localparam int ROW_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] MAX_WIDTH = DIM_W'(8192);
    localparam logic [DIM_W-1:0] MAX_ROWS  = DIM_W'(8192);

    localparam logic [PIX_W-1:0] THRESHOLD_RST  = PIX_W'(128);
    localparam logic [DIM_W-1:0] ROW_WIDTH_RST  = DIM_W'(8192);
    localparam logic [DIM_W-1:0] IMAGE_ROWS_RST = DIM_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 2'd0,
        CFG_ROW_WIDTH  = 2'd1,
        CFG_IMAGE_ROWS = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0] packed_bits;
        logic              row_end;
        logic              image_end;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/gtbp_ifs.sv @@
`default_nettype none

interface gtbp_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [gtbp_pkg::WORD_W-1:0]  pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

interface gtbp_result_if;
    logic                         valid;
    logic                         ready;
    logic [gtbp_pkg::WORD_W-1:0]  packed_bits;
    logic                         row_end;
    logic                         image_end;

    modport source (output valid, output packed_bits, output row_end, output image_end,
                    input ready);
    modport sink   (input valid, input packed_bits, input row_end, input image_end,
                    output ready);
endinterface

interface gtbp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gtbp_pkg::CFG_IDX_W-1:0]  index;
    logic [gtbp_pkg::DIM_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/gtbp_lane.sv @@
`default_nettype none

// One pixel compare; masked off past the row end.
module gtbp_lane (
    input  wire logic [gtbp_pkg::PIX_W-1:0] pixel,
    input  wire logic [gtbp_pkg::PIX_W-1:0] threshold,
    input  wire logic                       keep,
    output logic                            bit_out
);

    assign bit_out = keep && (pixel < threshold);

endmodule

`default_nettype wire

@@ rtl/gtbp_merge.sv @@
`default_nettype none

// Packs lane bits into groups of eight words and tracks row/image position.
module gtbp_merge (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        fire,
    input  wire logic [gtbp_pkg::LANES-1:0]  lane_bits,
    input  wire logic [gtbp_pkg::DIM_W-1:0]  row_width,
    input  wire logic [gtbp_pkg::DIM_W-1:0]  image_rows,
    output logic      [gtbp_pkg::LANES-1:0]  keep,
    output logic                             emit,
    output gtbp_pkg::result_t                res
);
    import gtbp_pkg::*;

    logic [ACC_W-1:0] acc_reg,   acc_next;
    logic [GRP_W-1:0] group_reg, group_next;
    logic [WIR_W-1:0] wir_reg,   wir_next;
    logic [ROW_W-1:0] row_reg,   row_next;

    logic [DIM_W-1:0]  rw_c, rows_c, rw_m1, rows_m1;
    logic [WIR_W-1:0]  words_m1;
    logic [GRP_W-1:0]  valid_m1;
    logic              last_word, last_row;
    logic [WORD_W-1:0] shifted;

    always_comb
    begin
        rw_c = row_width;
        if (row_width == '0)
            rw_c = DIM_W'(1);
        else if (row_width > MAX_WIDTH)
            rw_c = MAX_WIDTH;
        rows_c = image_rows;
        if (image_rows == '0)
            rows_c = DIM_W'(1);
        else if (image_rows > MAX_ROWS)
            rows_c = MAX_ROWS;

        rw_m1    = rw_c - DIM_W'(1);
        rows_m1  = rows_c - DIM_W'(1);
        words_m1 = WIR_W'(rw_m1 >> 3);
        valid_m1 = rw_m1[GRP_W-1:0];

        last_word = wir_reg >= words_m1;
        last_row  = DIM_W'(row_reg) >= rows_m1;

        for (int k = 0; k < LANES; k++)
        begin
            keep[k] = !last_word || (GRP_W'(k) <= valid_m1);
        end

        shifted = WORD_W'(lane_bits) << {group_reg, 3'b000};
        emit    = last_word || (group_reg == GRP_W'(LANES - 1));

        res.packed_bits = {{LANES{1'b0}}, acc_reg} | shifted;
        res.row_end     = last_word;
        res.image_end   = last_word && last_row;

        acc_next   = acc_reg;
        group_next = group_reg;
        wir_next   = wir_reg;
        row_next   = row_reg;
        if (fire)
        begin
            if (last_word)
            begin
                acc_next   = '0;
                group_next = '0;
                wir_next   = '0;
                row_next   = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else if (emit)
            begin
                acc_next   = '0;
                group_next = '0;
                wir_next   = wir_reg + WIR_W'(1);
            end
            else
            begin
                acc_next   = acc_reg | shifted[ACC_W-1:0];
                group_next = group_reg + GRP_W'(1);
                wir_next   = wir_reg + WIR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            group_reg <= '0;
            wir_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            group_reg <= group_next;
            wir_reg   <= wir_next;
            row_reg   <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gray_threshold_bit_packer_core.sv @@
// Grey-to-binary threshold packer, eight compare lanes feeding one packing stage.
// Throughput: one word per cycle while the skid entry is empty; every eighth
// word (or a row's last) yields a result, which is registered before output.
// Output register plus one skid entry decouple input ready from output ready.
// Reset (rst_n, async low): counters and accumulator clear, threshold 128,
// row width 8192, one row per image; no clearing pass.
`default_nettype none

module gray_threshold_bit_packer_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    gtbp_cfg_if.sink    cfg,
    gtbp_pixel_if.sink  pixel_in,
    gtbp_result_if.source result_out
);
    import gtbp_pkg::*;

    // Configuration registers
    logic [PIX_W-1:0] threshold_reg;
    logic [DIM_W-1:0] row_width_reg;
    logic [DIM_W-1:0] image_rows_reg;

    // Output register and skid entry
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic              fire;
    logic              emit;
    logic [LANES-1:0]  keep;
    logic [LANES-1:0]  lane_bits;
    result_t           res;
    logic              out_taken;

    // Config writes are always taken; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RST;
            row_width_reg  <= ROW_WIDTH_RST;
            image_rows_reg <= IMAGE_ROWS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_THRESHOLD:  threshold_reg  <= cfg.data[PIX_W-1:0];
                CFG_ROW_WIDTH:  row_width_reg  <= cfg.data;
                CFG_IMAGE_ROWS: image_rows_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // Input stalls only when the skid entry is occupied.
    assign pixel_in.ready = !skid_valid_reg;
    assign fire           = pixel_in.valid && !skid_valid_reg;

    // Compare lanes, one per byte of the word
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        gtbp_lane u_lane (
            .pixel     (pixel_in.pixel_word[k*PIX_W +: PIX_W]),
            .threshold (threshold_reg),
            .keep      (keep[k]),
            .bit_out   (lane_bits[k])
        );
    end

    // Packing and row/image position
    gtbp_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .lane_bits  (lane_bits),
        .row_width  (row_width_reg),
        .image_rows (image_rows_reg),
        .keep       (keep),
        .emit       (emit),
        .res        (res)
    );

    assign out_taken = out_valid_reg && result_out.ready;

    // Output register with a one-word skid behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // no input accepted while skid is full
            if (out_taken)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || result_out.ready)
        begin
            out_valid_reg <= fire && emit;
        end
        else if (fire && emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_taken)
                out_reg <= skid_reg;
        end
        else if (!out_valid_reg || result_out.ready)
        begin
            if (fire && emit)
                out_reg <= res;
        end
        else if (fire && emit)
        begin
            skid_reg <= res;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.packed_bits = out_reg.packed_bits;
    assign result_out.row_end     = out_reg.row_end;
    assign result_out.image_end   = out_reg.image_end;

endmodule

`default_nettype wire

@@ test/tb.sv @@
`default_nettype none

// Checks the grey threshold packer against a predictor kept here. A word is one
// pixel_in handshake: eight pixels in, at most one packed result out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gtbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES  = 4;     // drain margin after the owed queue empties
    localparam int RANDOM_WORDS   = 600;
    localparam int PRINT_CAP      = 40;

    // Index past the register list, the block must ignore it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic {ROW_CFG, ROW_WORD} step_kind_t;
    typedef enum logic [1:0] {RECV_OPEN, RECV_STALL, RECV_FLICKER} recv_mode_t;

    // One row of the directed script. For a ROW_WORD with typed set, want is
    // the result worked out by hand and replaces the predicted one.
    typedef struct packed {
        step_kind_t              kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [WORD_W-1:0]       value;
        logic                    typed;
        result_t                 want;
    } step_t;

    localparam result_t NO_WANT = '0;
    localparam int      N_STEPS = 40;

    localparam step_t SCRIPT [N_STEPS] = '{
        // one-word rows, two-row image
        '{ROW_CFG,  CFG_ROW_WIDTH,  64'd8,                 1'b0, NO_WANT},
        '{ROW_CFG,  CFG_IMAGE_ROWS, 64'd2,                 1'b0, NO_WANT},
        // all pixels dark, then all bright, then alternating around 128
        '{ROW_WORD, CFG_THRESHOLD,  64'h0,                 1'b1, {64'hff, 1'b1, 1'b0}},
        '{ROW_WORD, CFG_THRESHOLD,  64'hffff_ffff_ffff_ffff, 1'b1, {64'h00, 1'b1, 1'b1}},
        '{ROW_WORD, CFG_THRESHOLD,  64'h7f80_7f80_7f80_7f80, 1'b1, {64'haa, 1'b1, 1'b0}},
        // threshold zero: nothing is below it
        '{ROW_CFG,  CFG_THRESHOLD,  64'd0,                 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h0,                 1'b1, {64'h00, 1'b1, 1'b1}},
        // oversized write, cut to 255
        '{ROW_CFG,  CFG_THRESHOLD,  64'h3fff,              1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'hfefe_fefe_fefe_fefe, 1'b1, {64'hff, 1'b1, 1'b0}},
        '{ROW_WORD, CFG_THRESHOLD,  64'hffff_ffff_ffff_ffff, 1'b1, {64'h00, 1'b1, 1'b1}},
        // write to an unused index leaves threshold at 255
        '{ROW_CFG,  CFG_SPARE,      64'd1,                 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'hfefe_fefe_fefe_fefe, 1'b1, {64'hff, 1'b1, 1'b0}},
        // threshold back to 128 through upper garbage; row width zero acts as 1
        '{ROW_CFG,  CFG_THRESHOLD,  64'h3f80,              1'b0, NO_WANT},
        '{ROW_CFG,  CFG_ROW_WIDTH,  64'd0,                 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h0,                 1'b1, {64'h01, 1'b1, 1'b1}},
        '{ROW_WORD, CFG_THRESHOLD,  64'h0123_4567_89ab_cdef, 1'b0, NO_WANT},
        // 20-pixel rows: short final word keeps four bits; zero rows acts as 1
        '{ROW_CFG,  CFG_ROW_WIDTH,  64'd20,                1'b0, NO_WANT},
        '{ROW_CFG,  CFG_IMAGE_ROWS, 64'd0,                 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h0,                 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h0,                 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h0,                 1'b1, {64'h0f_ffff, 1'b1, 1'b1}},
        // two words into a row, then the row is shrunk under it
        '{ROW_WORD, CFG_THRESHOLD,  64'h0123_4567_89ab_cdef, 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'hfedc_ba98_7654_3210, 1'b0, NO_WANT},
        '{ROW_CFG,  CFG_ROW_WIDTH,  64'd8,                 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h8080_7f7f_0000_ffff, 1'b0, NO_WANT},
        // image cut short while on its third row
        '{ROW_CFG,  CFG_IMAGE_ROWS, 64'd3,                 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h00ff_00ff_7f80_8000, 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h5a5a_a5a5_c3c3_3c3c, 1'b0, NO_WANT},
        '{ROW_CFG,  CFG_IMAGE_ROWS, 64'd2,                 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h7f7f_7f7f_7f7f_7f7f, 1'b0, NO_WANT},
        // widest row and tallest image, clamped; a full eight-word group
        '{ROW_CFG,  CFG_ROW_WIDTH,  64'h3fff,              1'b0, NO_WANT},
        '{ROW_CFG,  CFG_IMAGE_ROWS, 64'h3fff,              1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h0,                 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'hffff_ffff_ffff_ffff, 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h7f80_7f80_7f80_7f80, 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h8080_8080_8080_8080, 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h7f7f_7f7f_7f7f_7f7f, 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h0123_4567_89ab_cdef, 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'hfedc_ba98_7654_3210, 1'b0, NO_WANT},
        '{ROW_WORD, CFG_THRESHOLD,  64'h0,                 1'b0, NO_WANT}
    };

    logic clk;
    logic rst_n;

    gtbp_cfg_if    cfg_bus ();
    gtbp_pixel_if  pix_bus ();
    gtbp_result_if res_bus ();

    gray_threshold_bit_packer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .pixel_in   (pix_bus),
        .result_out (res_bus)
    );

    always #6 clk = ~clk;

    // Predictor copy of the registers and packing state, reset values.
    logic [PIX_W-1:0] thr_cfg   = THRESHOLD_RST;
    logic [DIM_W-1:0] width_cfg = ROW_WIDTH_RST;
    logic [DIM_W-1:0] rows_cfg  = IMAGE_ROWS_RST;
    logic [ACC_W-1:0] bit_acc   = '0;
    logic [GRP_W-1:0] group_pos = '0;
    logic [WIR_W-1:0] word_pos  = '0;
    logic [ROW_W-1:0] row_pos   = '0;

    result_t packed_due [$];   // packed words still owed by the block
    int      mismatches = 0;
    int      quiet      = 0;

    // Sender pacing: bursts of words separated by random gaps.
    logic bursty     = 1'b0;
    int   burst_left = 1;

    // Receiver pattern state.
    recv_mode_t recv_mode = RECV_OPEN;
    int         recv_left = 0;

    // Threshold one pixel word, fold it into the group; returns 1 when a
    // packed word is due and fills it in.
    function automatic logic binarize_and_pack(input logic [WORD_W-1:0] w,
                                               output result_t r);
        int unsigned       width_px;
        int unsigned       rows_n;
        int unsigned       words_n;
        int unsigned       live;
        logic [LANES-1:0]  lane_bits;
        logic [WORD_W-1:0] merged;
        logic              last_word;
        logic              last_row;

        width_px = (width_cfg == 0) ? 1 : (width_cfg > MAX_WIDTH) ? MAX_WIDTH : width_cfg;
        rows_n   = (rows_cfg == 0) ? 1 : (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
        words_n  = (width_px + 7) / 8;
        // a shrunk row or image ends at once when already past its end
        last_word = (word_pos >= words_n - 1);
        last_row  = (row_pos >= rows_n - 1);

        for (int k = 0; k < LANES; k++)
            lane_bits[k] = (w[k*PIX_W +: PIX_W] < thr_cfg);
        if (last_word)
        begin
            // pixels past the row's end read as zero
            live = width_px - (words_n - 1) * 8;
            lane_bits &= LANES'((16'd1 << live) - 1);
        end
        merged = {{LANES{1'b0}}, bit_acc} | (WORD_W'(lane_bits) << (group_pos * PIX_W));
        r = '0;

        if (last_word)
        begin
            r.packed_bits = merged;
            r.row_end     = 1'b1;
            r.image_end   = last_row;
            bit_acc   = '0;
            group_pos = '0;
            word_pos  = '0;
            row_pos   = last_row ? '0 : row_pos + 1'b1;
            return 1'b1;
        end
        if (group_pos == GRP_W'(LANES - 1))
        begin
            r.packed_bits = merged;
            bit_acc   = '0;
            group_pos = '0;
            word_pos  = word_pos + 1'b1;
            return 1'b1;
        end
        bit_acc   = merged[ACC_W-1:0];
        group_pos = group_pos + 1'b1;
        word_pos  = word_pos + 1'b1;
        return 1'b0;
    endfunction

    // Random pixels, biased toward the threshold edge and the byte extremes.
    function automatic logic [WORD_W-1:0] pick_pixels();
        logic [WORD_W-1:0] w;

        w = {$urandom, $urandom};
        if ($urandom_range(0, 7) != 0)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                case ($urandom_range(0, 5))
                    0: w[k*PIX_W +: PIX_W] = '0;
                    1: w[k*PIX_W +: PIX_W] = '1;
                    2: w[k*PIX_W +: PIX_W] = thr_cfg;
                    3: w[k*PIX_W +: PIX_W] = thr_cfg - 1'b1;
                    default: ;
                endcase
            end
        end
        return w;
    endfunction

    task automatic report(input string what, input logic [WORD_W-1:0] got,
                          input logic [WORD_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Register write; valid is left high so back-to-back writes stay
    // back to back. The next word or hold-off drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DIM_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            CFG_THRESHOLD:  thr_cfg   = value[PIX_W-1:0];
            CFG_ROW_WIDTH:  width_cfg = value;
            CFG_IMAGE_ROWS: rows_cfg  = value;
            default: ;
        endcase
    endtask

    // Send one word, predict at the accepting edge, then maybe take a gap.
    task automatic push_word(input logic [WORD_W-1:0] w, input logic typed,
                             input result_t want);
        result_t r;
        logic    due;

        if (cfg_bus.valid)
            cfg_bus.valid <= 1'b0;
        pix_bus.valid      <= 1'b1;
        pix_bus.pixel_word <= w;
        do @(posedge clk); while (!pix_bus.ready);
        due = binarize_and_pack(w, r);
        if (typed)
        begin
            r   = want;
            due = 1'b1;
        end
        if (due)
            packed_due.push_back(r);
        if (bursty)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                pix_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    // Quiet the inputs and drain: a word that yields nothing may still be in
    // flight once the queue is empty, so a settle margin follows the drain.
    task automatic hold_off();
        if (pix_bus.valid)
            pix_bus.valid <= 1'b0;
        if (cfg_bus.valid)
            cfg_bus.valid <= 1'b0;
        while (packed_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: open stretches, hard stalls and cycle-by-cycle flicker.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
        begin
            if (recv_left <= 0)
            begin
                case ($urandom_range(0, 3))
                    0, 1:
                    begin
                        recv_mode = RECV_OPEN;
                        recv_left = $urandom_range(1, 40);
                    end
                    2:
                    begin
                        recv_mode = RECV_STALL;
                        recv_left = $urandom_range(1, 12);
                    end
                    default:
                    begin
                        recv_mode = RECV_FLICKER;
                        recv_left = $urandom_range(4, 20);
                    end
                endcase
            end
            recv_left--;
            case (recv_mode)
                RECV_OPEN:  res_bus.ready <= 1'b1;
                RECV_STALL: res_bus.ready <= 1'b0;
                default:    res_bus.ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // Result check against the oldest owed word, field by field.
    always @(posedge clk)
    begin
        result_t want;

        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (packed_due.size() == 0)
                report("unexpected word", res_bus.packed_bits, '0);
            else
            begin
                want = packed_due.pop_front();
                if (res_bus.packed_bits !== want.packed_bits)
                    report("packed_bits", res_bus.packed_bits, want.packed_bits);
                if (res_bus.row_end !== want.row_end)
                    report("row_end", WORD_W'(res_bus.row_end), WORD_W'(want.row_end));
                if (res_bus.image_end !== want.image_end)
                    report("image_end", WORD_W'(res_bus.image_end), WORD_W'(want.image_end));
            end
        end
    end

    // Watchdog on handshake activity of any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet <= 0;
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        int unsigned random_words;
        int unsigned phase_len;
        logic        prev_word;
        logic [PIX_W-1:0] thr_pick;

        random_words       = 0;
        prev_word          = 1'b0;
        clk                = 1'b0;
        rst_n              = 1'b0;
        pix_bus.valid      = 1'b0;
        pix_bus.pixel_word = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = CFG_THRESHOLD;
        cfg_bus.data       = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script; register rows only once the block has gone quiet.
        bursty     = 1'b1;
        burst_left = $urandom_range(1, 6);
        for (int i = 0; i < N_STEPS; i++)
        begin
            if (SCRIPT[i].kind == ROW_CFG)
            begin
                if (prev_word)
                    hold_off();
                write_reg(SCRIPT[i].idx, SCRIPT[i].value[DIM_W-1:0]);
                prev_word = 1'b0;
            end
            else
            begin
                push_word(SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].want);
                prev_word = 1'b1;
            end
        end

        // Random phases: drain, rewrite some registers (often mid-row or
        // mid-image, since phases end anywhere), then a run of words.
        while (random_words < RANDOM_WORDS)
        begin
            hold_off();
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 4))
                    0:       thr_pick = '0;
                    1:       thr_pick = '1;
                    default: thr_pick = PIX_W'($urandom);
                endcase
                write_reg(CFG_THRESHOLD, {(DIM_W-PIX_W)'($urandom), thr_pick});
            end
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       write_reg(CFG_ROW_WIDTH, '0);
                    1:       write_reg(CFG_ROW_WIDTH, '1);
                    2:       write_reg(CFG_ROW_WIDTH, MAX_WIDTH);
                    3:       write_reg(CFG_ROW_WIDTH, DIM_W'($urandom_range(8193, 16383)));
                    4, 5:    write_reg(CFG_ROW_WIDTH, DIM_W'($urandom_range(65, 400)));
                    default: write_reg(CFG_ROW_WIDTH, DIM_W'($urandom_range(1, 64)));
                endcase
            end
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 7))
                    0:       write_reg(CFG_IMAGE_ROWS, '0);
                    1:       write_reg(CFG_IMAGE_ROWS, '1);
                    2:       write_reg(CFG_IMAGE_ROWS, MAX_ROWS);
                    3:       write_reg(CFG_IMAGE_ROWS, DIM_W'($urandom_range(8193, 16383)));
                    default: write_reg(CFG_IMAGE_ROWS, DIM_W'($urandom_range(1, 6)));
                endcase
            end
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_SPARE, DIM_W'($urandom));

            // about one phase in four streams back to back
            bursty     = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 16);
            phase_len  = $urandom_range(10, 60);
            repeat (phase_len)
            begin
                push_word(pick_pixels(), 1'b0, NO_WANT);
                random_words++;
            end
        end

        hold_off();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
